// File: rtl/core/mnc_pkg.sv
// shared widths, register indexes and word types for the mine neighbour counter
package mnc_pkg;

	localparam int ROW_W    = 16;   // cells carried by one row word
	localparam int IDX_W    = 10;   // row index width
	localparam int CNT_W    = 4;    // one neighbour count nibble
	localparam int COLS_W   = 5;    // num_cols register width
	localparam int ROWS_W   = 11;   // num_rows register width
	localparam int MAX_ROWS = 1024;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = ROWS_W;
	localparam int OUT_DATA_W = 96; // row_index, mine_mask, counts, padded to bytes

	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b1;

	// one row to be evaluated, with its neighbours above and below
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [ROW_W-1:0] up;
		logic [ROW_W-1:0] mid;
		logic [ROW_W-1:0] down;
		logic             done;
	} row_req_t;

	// one finished result word
	typedef struct packed {
		logic [IDX_W-1:0]       idx;
		logic [ROW_W-1:0]       mask;
		logic [ROW_W*CNT_W-1:0] counts;
		logic                   done;
	} row_res_t;

endpackage

// File: rtl/core/mnc_lane.sv
// one cell lane: counts the mines among the eight neighbours of a cell
module mnc_lane
	import mnc_pkg::*;
(
	input  logic [2:0]       up_bits,
	input  logic [1:0]       side_bits,
	input  logic [2:0]       down_bits,
	input  logic             self_bit,
	output logic [CNT_W-1:0] count
);

	logic [CNT_W-1:0] sum;

	// popcount of the eight neighbour bits
	always_comb begin
		sum = CNT_W'(up_bits[0]) + CNT_W'(up_bits[1]) + CNT_W'(up_bits[2])
		    + CNT_W'(side_bits[0]) + CNT_W'(side_bits[1])
		    + CNT_W'(down_bits[0]) + CNT_W'(down_bits[1]) + CNT_W'(down_bits[2]);
	end

	// a mine cell reports zero
	assign count = self_bit ? '0 : sum;

endmodule

// File: rtl/core/mnc_row_unit.sv
// row evaluator: masks the rows, runs one lane per cell and merges the nibbles
module mnc_row_unit
	import mnc_pkg::*;
#(
	parameter int ROW_CELLS = 16
) (
	input  row_req_t         req,
	input  logic [ROW_W-1:0] col_mask,
	output row_res_t         res
);

	logic [ROW_W-1:0]       up_m;
	logic [ROW_W-1:0]       mid_m;
	logic [ROW_W-1:0]       down_m;
	logic [ROW_W+1:0]       up_pad;
	logic [ROW_W+1:0]       mid_pad;
	logic [ROW_W+1:0]       down_pad;
	logic [ROW_W*CNT_W-1:0] counts;

	// drop cells past the column count, pad one empty cell on each side
	assign up_m     = req.up & col_mask;
	assign mid_m    = req.mid & col_mask;
	assign down_m   = req.down & col_mask;
	assign up_pad   = {1'b0, up_m, 1'b0};
	assign mid_pad  = {1'b0, mid_m, 1'b0};
	assign down_pad = {1'b0, down_m, 1'b0};

	// one lane per cell in use, unused cells give zero
	for (genvar j = 0; j < ROW_W; j++) begin : g_cell
		if (j < ROW_CELLS) begin : g_lane
			mnc_lane u_lane (
				.up_bits   (up_pad[j+2:j]),
				.side_bits ({mid_pad[j+2], mid_pad[j]}),
				.down_bits (down_pad[j+2:j]),
				.self_bit  (mid_pad[j+1]),
				.count     (counts[j*CNT_W +: CNT_W])
			);
		end else begin : g_empty
			assign counts[j*CNT_W +: CNT_W] = '0;
		end
	end

	// merge lane results into one word
	always_comb begin
		res.idx    = req.idx;
		res.mask   = mid_m;
		res.counts = counts;
		res.done   = req.done;
	end

endmodule

// File: rtl/core/mnc_out_fifo.sv
// two-entry result queue between the row evaluator and the output port
module mnc_out_fifo
	import mnc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  row_res_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output row_res_t head
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W_F = $clog2(DEPTH + 1);

	row_res_t           mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_F-1:0] level_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (level_q == CNT_W_F'(DEPTH));
	assign not_empty = (level_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/mine_neighbor_count.sv
// Results: a row's result is queued when the row below it is accepted; the
// final row of a grid is queued from its own registers after the result before it.
// Throughput: one row word per cycle while the result queue has room; input is held
// off after the final row of a grid, while that row's own result takes the row evaluator.
// Reset: arst_n clears row history, counters and queue; num_cols and num_rows go to 16.
module mine_neighbor_count
	import mnc_pkg::*;
#(
	parameter int ROW_CELLS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input row words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [ROW_W-1:0]      s_axis_tdata,   // [15:0] mine_row
	// result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [9:0] row_index, [25:10] mine_mask,
	                                              // [89:26] counts, [95:90] zero
	output logic                  m_axis_tlast    // grid_done
);

	logic [COLS_W-1:0] num_cols_q;
	logic [ROWS_W-1:0] num_rows_q;
	logic [COLS_W-1:0] eff_cols;
	logic [ROWS_W-1:0] eff_rows;
	logic [ROW_W-1:0]  col_mask;

	logic [ROW_W-1:0]  row_above_q;
	logic [ROW_W-1:0]  row_cur_q;
	logic [IDX_W-1:0]  row_cnt_q;
	logic              tail_v_q;
	logic [ROW_W-1:0]  tail_up_q;
	logic [ROW_W-1:0]  tail_mid_q;
	logic [IDX_W-1:0]  tail_idx_q;

	logic              accept;
	logic              last_row;
	logic [ROW_W-1:0]  row_in;
	row_req_t          req;
	row_res_t          res;
	row_res_t          head;
	logic              push;
	logic              fifo_full;
	logic              fifo_nempty;

	// configuration registers, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= COLS_W'(16);
			num_rows_q <= ROWS_W'(16);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_COLS: num_cols_q <= cfg_data[COLS_W-1:0];
				REG_NUM_ROWS: num_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp the grid size and build the column mask
	always_comb begin
		eff_cols = num_cols_q;
		if (eff_cols == '0) eff_cols = COLS_W'(1);
		if (eff_cols > COLS_W'(ROW_CELLS)) eff_cols = COLS_W'(ROW_CELLS);
		eff_rows = num_rows_q;
		if (eff_rows == '0) eff_rows = ROWS_W'(1);
		if (eff_rows > ROWS_W'(MAX_ROWS)) eff_rows = ROWS_W'(MAX_ROWS);
		for (int j = 0; j < ROW_W; j++) begin
			col_mask[j] = (COLS_W'(j) < eff_cols);
		end
	end

	// input handshake: hold off while the final row still waits its turn or the result queue is full
	assign s_axis_tready = !tail_v_q && !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign row_in        = s_axis_tdata & col_mask;
	assign last_row      = ({1'b0, row_cnt_q} + 1'b1) >= eff_rows;

	// select what the evaluator works on this cycle
	always_comb begin
		if (tail_v_q) begin
			req.idx  = tail_idx_q;
			req.up   = tail_up_q;
			req.mid  = tail_mid_q;
			req.down = '0;
			req.done = 1'b1;
			push     = !fifo_full;
		end else begin
			req.idx  = row_cnt_q - 1'b1;
			req.up   = row_above_q;
			req.mid  = row_cur_q;
			req.down = row_in;
			req.done = 1'b0;
			push     = accept && (row_cnt_q != '0);
		end
	end

	// row history and the pending final row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_above_q <= '0;
			row_cur_q   <= '0;
			row_cnt_q   <= '0;
			tail_v_q    <= 1'b0;
		end else begin
			if (tail_v_q && !fifo_full) begin
				tail_v_q <= 1'b0;
			end
			if (accept) begin
				if (last_row) begin
					row_above_q <= '0;
					row_cur_q   <= '0;
					row_cnt_q   <= '0;
					tail_v_q    <= 1'b1;
				end else begin
					row_above_q <= row_cur_q;
					row_cur_q   <= row_in;
					row_cnt_q   <= row_cnt_q + 1'b1;
				end
			end
		end
	end

	// final row payload
	always_ff @(posedge clk) begin
		if (accept && last_row) begin
			tail_up_q  <= row_cur_q;
			tail_mid_q <= row_in;
			tail_idx_q <= row_cnt_q;
		end
	end

	mnc_row_unit #(
		.ROW_CELLS (ROW_CELLS)
	) u_row_unit (
		.req      (req),
		.col_mask (col_mask),
		.res      (res)
	);

	mnc_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (fifo_full),
		.pop       (m_axis_tready),
		.not_empty (fifo_nempty),
		.head      (head)
	);

	// output word packing
	assign m_axis_tvalid = fifo_nempty;
	assign m_axis_tdata  = {{(OUT_DATA_W - IDX_W - ROW_W - ROW_W*CNT_W){1'b0}},
	                        head.counts, head.mask, head.idx};
	assign m_axis_tlast  = head.done;

endmodule

// File: rtl/core/mnc_checker.sv
// port checks for the mine neighbour counter, bound to the top level
module mnc_checker
	import mnc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tlast
);

	// a stalled result word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// a mine cell reports no neighbour count
	a_mine_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[29:26] == 4'd0)
		else $error("mine cell with nonzero count");

	// the first two cells never count more than eight neighbours
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[29:26] <= 4'd8 && m_axis_tdata[33:30] <= 4'd8)
		else $error("neighbour count above eight");

	// padding bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:90] == '0)
		else $error("padding bits set in result word");

	// row zero with grid_done set is a single-row grid: the first cell has no
	// rows above or below, so only its right neighbour can count
	a_corner: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[9:0] == 10'd0 && m_axis_tlast
			|-> m_axis_tdata[29:26] <= 4'd1)
		else $error("single-row corner count too high");

endmodule

bind mine_neighbor_count mnc_checker u_mnc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
